FILE: rtl/hmv_pkg.sv
package hmv_pkg;

  // datapath width of the cordic chain: inputs are prescaled to 2^56
  localparam int XW      = 60;
  localparam int ZW      = 26;
  localparam int SPEED_W = 24;
  localparam int HEAD_W  = 25;
  localparam int MOVE_W  = 25;
  localparam int PROD_W  = 56;

  localparam logic signed [ZW-1:0] FULL_TURN          = 26'sd23592960;
  localparam logic signed [ZW-1:0] HALF_TURN          = 26'sd11796480;
  localparam logic signed [ZW-1:0] QUARTER_TURN       = 26'sd5898240;
  localparam logic signed [ZW-1:0] THREE_QUARTER_TURN = 26'sd17694720;

  // 1 / cordic gain in q32
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  localparam logic signed [MOVE_W-1:0] MOVE_MAX = 25'sd16777215;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] a;
    logic signed [XW-1:0] b;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic               valid;
    logic               flip;
    logic               dx_zero;
    logic               dy_zero;
    logic               dx_neg;
    logic               dy_neg;
    logic [SPEED_W-1:0] speed;
  } side_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      5'd20:   v = 26'sd4;
      5'd21:   v = 26'sd2;
      5'd22:   v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/hmv_front.sv
module hmv_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic signed [COORD_WIDTH-1:0]   start_x,
  input  logic signed [COORD_WIDTH-1:0]   start_y,
  input  logic signed [COORD_WIDTH-1:0]   end_x,
  input  logic signed [COORD_WIDTH-1:0]   end_y,
  input  logic [hmv_pkg::SPEED_W-1:0]     speed,
  output hmv_pkg::cordic_t                data_out,
  output hmv_pkg::side_t                  side_out
);
  import hmv_pkg::*;

  localparam int PRESCALE = 56 - COORD_WIDTH;

  logic signed [COORD_WIDTH:0] dx, dx_next;
  logic signed [COORD_WIDTH:0] dy, dy_next;
  logic [PROD_W-1:0]           prod, prod_next;
  logic [SPEED_W-1:0]          speed_a;
  logic                        valid_a;

  cordic_t data_next;
  side_t   side_next;

  always_comb begin
    dx_next   = {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
    dy_next   = {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
    prod_next = PROD_W'(speed) * PROD_W'(INV_GAIN_Q32);
  end

  always_ff @(posedge clk) begin
    dx      <= dx_next;
    dy      <= dy_next;
    prod    <= prod_next;
    speed_a <= speed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= load;
    end
  end

  // vectoring pair is (up, right) = (-dy, dx), turned by 180 when up is negative
  always_comb begin
    logic signed [XW-1:0] sdx;
    logic signed [XW-1:0] sdy;
    sdx = XW'(dx) <<< PRESCALE;
    sdy = XW'(dy) <<< PRESCALE;
    side_next.valid   = valid_a;
    side_next.dx_zero = (dx == '0);
    side_next.dy_zero = (dy == '0);
    side_next.dx_neg  = dx[COORD_WIDTH];
    side_next.dy_neg  = dy[COORD_WIDTH];
    side_next.flip    = !dy[COORD_WIDTH] && (dy != '0);
    side_next.speed   = speed_a;
    data_next.x = side_next.flip ? sdy : -sdy;
    data_next.y = side_next.flip ? -sdx : sdx;
    data_next.a = XW'(prod);
    data_next.b = '0;
    data_next.z = '0;
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_next;
    end
  end

endmodule

FILE: rtl/hmv_cell.sv
module hmv_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  hmv_pkg::cordic_t data_in,
  input  hmv_pkg::side_t   side_in,
  output hmv_pkg::cordic_t data_out,
  output hmv_pkg::side_t   side_out
);
  import hmv_pkg::*;

  localparam logic [4:0] IDX = 5'(STAGE);

  cordic_t data_next;

  // vectoring step on (x, y, z); rotation step on (a, b) replays its decision
  always_comb begin
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] a;
    logic signed [XW-1:0] b;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] as;
    logic signed [XW-1:0] bs;
    logic                 up;
    x  = data_in.x;
    y  = data_in.y;
    a  = data_in.a;
    b  = data_in.b;
    xs = x >>> STAGE;
    ys = y >>> STAGE;
    as = a >>> STAGE;
    bs = b >>> STAGE;
    up = !y[XW-1];
    if (up) begin
      data_next.x = x + ys;
      data_next.y = y - xs;
      data_next.z = data_in.z + atan_deg(IDX);
      data_next.a = a - bs;
      data_next.b = b + as;
    end else begin
      data_next.x = x - ys;
      data_next.y = y + xs;
      data_next.z = data_in.z - atan_deg(IDX);
      data_next.a = a + bs;
      data_next.b = b - as;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else begin
      side_out <= side_in;
    end
  end

  // x starts non-negative and only grows
  assert property (@(posedge clk) disable iff (rst)
    side_out.valid |-> !data_out.x[XW-1])
    else $error("cordic x went negative");

endmodule

FILE: rtl/hmv_back.sv
module hmv_back (
  input  logic                             clk,
  input  logic                             rst,
  input  hmv_pkg::cordic_t                 data_in,
  input  hmv_pkg::side_t                   side_in,
  output logic                             done,
  output logic [hmv_pkg::HEAD_W-1:0]       heading,
  output logic signed [hmv_pkg::MOVE_W-1:0] move_x,
  output logic signed [hmv_pkg::MOVE_W-1:0] move_y
);
  import hmv_pkg::*;

  localparam int RW = XW - 32;
  localparam logic signed [XW-1:0] ROUND_HALF = XW'(64'd2147483648);

  function automatic logic signed [MOVE_W-1:0] round_sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    logic signed [RW-1:0] r;
    logic signed [MOVE_W-1:0] o;
    s = v + ROUND_HALF;
    r = s[XW-1:32];
    if (r > RW'(MOVE_MAX)) begin
      o = MOVE_MAX;
    end else if (r < -RW'(MOVE_MAX)) begin
      o = -MOVE_MAX;
    end else begin
      o = MOVE_W'(r);
    end
    return o;
  endfunction

  logic [HEAD_W-1:0]    head_f, head_f_next;
  logic signed [XW-1:0] a_f, b_f;
  side_t                side_f;

  // undo the half turn and wrap the heading
  always_comb begin
    logic signed [ZW-1:0] t;
    t = data_in.z + (side_in.flip ? HALF_TURN : '0);
    if (t < 0) begin
      t = t + FULL_TURN;
    end else if (t >= FULL_TURN) begin
      t = t - FULL_TURN;
    end
    head_f_next = HEAD_W'(t);
  end

  always_ff @(posedge clk) begin
    head_f <= head_f_next;
    a_f    <= side_in.flip ? -data_in.a : data_in.a;
    b_f    <= side_in.flip ? -data_in.b : data_in.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_f <= '0;
    end else begin
      side_f <= side_in;
    end
  end

  logic [HEAD_W-1:0]        heading_next;
  logic signed [MOVE_W-1:0] move_x_next, move_y_next;

  always_comb begin
    logic signed [MOVE_W-1:0] spd;
    spd = $signed({1'b0, side_f.speed});
    if (side_f.dx_zero && side_f.dy_zero) begin
      heading_next = '0;
      move_x_next  = '0;
      move_y_next  = '0;
    end else if (side_f.dx_zero) begin
      heading_next = side_f.dy_neg ? '0 : HEAD_W'(HALF_TURN);
      move_x_next  = '0;
      move_y_next  = side_f.dy_neg ? -spd : spd;
    end else if (side_f.dy_zero) begin
      heading_next = side_f.dx_neg ? HEAD_W'(THREE_QUARTER_TURN) : HEAD_W'(QUARTER_TURN);
      move_x_next  = side_f.dx_neg ? -spd : spd;
      move_y_next  = '0;
    end else begin
      heading_next = head_f;
      move_x_next  = round_sat(b_f);
      move_y_next  = -round_sat(a_f);
    end
  end

  always_ff @(posedge clk) begin
    heading <= heading_next;
    move_x  <= move_x_next;
    move_y  <= move_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_f.valid;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, heading} < FULL_TURN))
    else $error("heading out of range");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (move_x <= MOVE_MAX && move_x >= -MOVE_MAX &&
              move_y <= MOVE_MAX && move_y >= -MOVE_MAX))
    else $error("move vector not saturated");

endmodule

FILE: rtl/heading_and_move_vector.sv
// an item runs through the front registers, the cordic cells and the back registers to done
// throughput: one item per cycle; the chain of CORDIC_STAGES cells is fully pipelined
// busy is low except during reset; the receiver cannot stall and takes done as a pulse
// reset (rst, synchronous) clears the valid bits along the pipe; items in flight are dropped
module heading_and_move_vector #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     start_x,
  input  logic signed [COORD_WIDTH-1:0]     start_y,
  input  logic signed [COORD_WIDTH-1:0]     end_x,
  input  logic signed [COORD_WIDTH-1:0]     end_y,
  input  logic [hmv_pkg::SPEED_W-1:0]       speed,
  output logic                              done,
  output logic [hmv_pkg::HEAD_W-1:0]        heading,
  output logic signed [hmv_pkg::MOVE_W-1:0] move_x,
  output logic signed [hmv_pkg::MOVE_W-1:0] move_y
);
  import hmv_pkg::*;

  localparam int LAT = CORDIC_STAGES + 4;

  logic    load;
  cordic_t data [CORDIC_STAGES+1];
  side_t   side [CORDIC_STAGES+1];

  assign busy = rst;
  assign load = start && !busy;

  hmv_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .speed   (speed),
    .data_out(data[0]),
    .side_out(side[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    hmv_cell #(
      .STAGE(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .data_in (data[i]),
      .side_in (side[i]),
      .data_out(data[i+1]),
      .side_out(side[i+1])
    );
  end

  hmv_back u_back (
    .clk    (clk),
    .rst    (rst),
    .data_in(data[CORDIC_STAGES]),
    .side_in(side[CORDIC_STAGES]),
    .done   (done),
    .heading(heading),
    .move_x (move_x),
    .move_y (move_y)
  );

  assert property (@(posedge clk) disable iff (rst)
    load |-> ##LAT done)
    else $error("result transfer missing after start");

endmodule
